// ===== rtl/core/bounded_deque_with_stats_assert.svh =====
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_STATS_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_STATS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDWS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bdws_pkg.sv =====
// Package: sizes, command and status codes, ring index helpers.
`timescale 1ns / 1ps
package bdws_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int USED_W   = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 3;
	localparam int VAL_W    = 31;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;
	localparam int TOTAL_W  = 37;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_REMOVE     = 3'd2,
		CMD_CLEAR      = 3'd3,
		CMD_STATS      = 3'd4,
		CMD_DUMP       = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	// Physical slot of logical position k; front + k stays below twice the depth.
	function automatic logic [IDX_W-1:0] slot_f(logic [IDX_W-1:0] front,
			logic [USED_W-1:0] k);
		logic [USED_W:0] s;
		s = (USED_W+1)'(front) + (USED_W+1)'(k);
		if (s >= (USED_W+1)'(CAPACITY)) begin
			s = s - (USED_W+1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	// Entry count as reported, wrapped to the field width.
	function automatic logic [COUNT_W-1:0] count_f(logic [USED_W-1:0] used);
		logic [USED_W+COUNT_W-1:0] ext;
		ext = (USED_W+COUNT_W)'(used);
		return ext[COUNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/bdws_req_if.sv =====
// Command channel: valid/ready with command code and value.
`timescale 1ns / 1ps
interface bdws_req_if import bdws_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [VAL_W-1:0] value;

	modport source(output valid, cmd, value, input ready);
	modport sink(input valid, cmd, value, output ready);
endinterface

// ===== rtl/core/bdws_rsp_if.sv =====
// Result channel: valid/ready with status, entry, count and statistics.
`timescale 1ns / 1ps
interface bdws_rsp_if import bdws_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [VAL_W-1:0]   item;
	logic [COUNT_W-1:0] count;
	logic [VAL_W-1:0]   minimum;
	logic [VAL_W-1:0]   maximum;
	logic [TOTAL_W-1:0] total;
	logic               last;

	modport source(output valid, status, item, count, minimum, maximum, total, last,
		input ready);
	modport sink(input valid, status, item, count, minimum, maximum, total, last,
		output ready);
endinterface

// ===== rtl/core/bdws_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module bdws_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bounded_deque_with_stats.sv =====
// Deque top: ring store in RAM, command sequencer and registered result.
// Push, clear, unknown and empty-store commands: result registered on accept.
// Remove and stats walk the entries one RAM read per cycle, then the result is registered.
// Dump gives one item per cycle after a RAM read, slower if the sink stalls.
// One command at a time; the next is taken once its last result is registered and read.
// Async reset empties the deque; RAM contents are not cleared and never read before written.
`timescale 1ns / 1ps
`include "bounded_deque_with_stats_assert.svh"
module bounded_deque_with_stats import bdws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bdws_req_if.sink   req,
	bdws_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DUMP,
		ST_DONE
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [VAL_W-1:0]   val_q;
	logic [IDX_W-1:0]   front_q;
	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  rd_q;
	logic [USED_W-1:0]  em_q;
	logic               rv_s1;
	logic [USED_W-1:0]  ri_s1;
	logic               found_q;
	logic [VAL_W-1:0]   mn_q;
	logic [VAL_W-1:0]   mx_q;
	logic [TOTAL_W-1:0] sum_q;
	status_t            st_q;

	logic               res_valid_q;
	status_t            res_status_q;
	logic [VAL_W-1:0]   res_item_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [VAL_W-1:0]   res_min_q;
	logic [VAL_W-1:0]   res_max_q;
	logic [TOTAL_W-1:0] res_total_q;
	logic               res_last_q;

	logic               acc;
	logic               out_free;
	logic               full;
	logic               empty;
	logic               issue;
	logic               scan_end;
	logic               first;
	logic               dump_last;
	logic [IDX_W-1:0]   front_m1;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	bdws_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VAL_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !res_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign full      = (used_q == USED_W'(CAPACITY));
	assign empty     = (used_q == '0);
	assign issue     = (rd_q < used_q);
	assign scan_end  = (ri_s1 == used_q - 1'b1);
	assign first     = (ri_s1 == '0);
	assign dump_last = (em_q == used_q - 1'b1);
	assign front_m1  = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;

	assign rsp.valid   = res_valid_q;
	assign rsp.status  = res_status_q;
	assign rsp.item    = res_item_q;
	assign rsp.count   = res_count_q;
	assign rsp.minimum = res_min_q;
	assign rsp.maximum = res_max_q;
	assign rsp.total   = res_total_q;
	assign rsp.last    = res_last_q;

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_f(front_q, used_q);
		ram_wdata = req.value;
		ram_re    = 1'b0;
		ram_raddr = slot_f(front_q, rd_q);
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !full) begin
					if (cmd_t'(req.cmd) == CMD_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = front_m1;
					end else if (cmd_t'(req.cmd) == CMD_PUSH_BACK) begin
						ram_we = 1'b1;
					end
				end
				if (acc && !empty && cmd_t'(req.cmd) == CMD_DUMP) begin
					ram_re    = 1'b1;
					ram_raddr = front_q;
				end
			end
			ST_SCAN: begin
				ram_re = issue;
				// entries after the match move down by one
				ram_we    = rv_s1 && found_q;
				ram_waddr = slot_f(front_q, ri_s1 - 1'b1);
				ram_wdata = ram_rdata;
			end
			ST_DUMP: begin
				ram_re = out_free && !dump_last;
			end
			ST_DONE: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			front_q     <= '0;
			rd_q        <= '0;
			em_q        <= '0;
			rv_s1       <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rv_s1 <= 1'b0;
					if (acc) begin
						cmd_q        <= cmd_t'(req.cmd);
						val_q        <= req.value;
						rd_q         <= '0;
						found_q      <= 1'b0;
						mn_q         <= '0;
						mx_q         <= '0;
						sum_q        <= '0;
						res_valid_q  <= 1'b1;
						res_status_q <= STS_OK;
						res_item_q   <= '0;
						res_count_q  <= count_f(used_q);
						res_min_q    <= '0;
						res_max_q    <= '0;
						res_total_q  <= '0;
						res_last_q   <= 1'b1;
						case (cmd_t'(req.cmd))
							CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
								if (full) begin
									res_status_q <= STS_FULL;
								end else begin
									used_q      <= used_q + 1'b1;
									res_count_q <= count_f(used_q + 1'b1);
									if (cmd_t'(req.cmd) == CMD_PUSH_FRONT) begin
										front_q <= front_m1;
									end
								end
							end
							CMD_CLEAR: begin
								if (empty) begin
									res_status_q <= STS_EMPTY;
								end else begin
									used_q      <= '0;
									front_q     <= '0;
									res_count_q <= '0;
								end
							end
							CMD_REMOVE, CMD_STATS: begin
								if (empty) begin
									res_status_q <= STS_EMPTY;
								end else begin
									res_valid_q <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							CMD_DUMP: begin
								if (empty) begin
									res_status_q <= STS_EMPTY;
								end else begin
									res_valid_q <= 1'b0;
									rd_q        <= USED_W'(1);
									em_q        <= '0;
									state_q     <= ST_DUMP;
								end
							end
							default: begin
								res_status_q <= STS_OK;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					rv_s1 <= issue;
					ri_s1 <= rd_q;
					if (rv_s1) begin
						if (cmd_q == CMD_STATS) begin
							if (first || ram_rdata < mn_q) begin
								mn_q <= ram_rdata;
							end
							if (first || ram_rdata > mx_q) begin
								mx_q <= ram_rdata;
							end
							sum_q <= (first ? '0 : sum_q) + TOTAL_W'(ram_rdata);
							if (scan_end) begin
								st_q    <= STS_OK;
								state_q <= ST_DONE;
							end
						end else if (!found_q) begin
							if (ram_rdata == val_q) begin
								if (first || scan_end) begin
									// match at either end: no entries to move
									used_q  <= used_q - 1'b1;
									st_q    <= STS_OK;
									state_q <= ST_DONE;
									if (used_q == USED_W'(1)) begin
										front_q <= '0;
									end else if (first) begin
										front_q <= slot_f(front_q, USED_W'(1));
									end
								end else begin
									found_q <= 1'b1;
								end
							end else if (scan_end) begin
								st_q    <= STS_NOT_FOUND;
								state_q <= ST_DONE;
							end
						end else if (scan_end) begin
							used_q  <= used_q - 1'b1;
							st_q    <= STS_OK;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_status_q <= STS_OK;
						res_item_q   <= ram_rdata;
						res_count_q  <= count_f(used_q);
						res_min_q    <= '0;
						res_max_q    <= '0;
						res_total_q  <= '0;
						res_last_q   <= dump_last;
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q + 1'b1;
							em_q <= em_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_status_q <= st_q;
						res_item_q   <= '0;
						res_count_q  <= count_f(used_q);
						res_min_q    <= mn_q;
						res_max_q    <= mx_q;
						res_total_q  <= sum_q;
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`BDWS_ASSERT_IMP(a_used_bound, 1'b1, used_q <= USED_W'(CAPACITY), "entry count above capacity")
	`BDWS_ASSERT_IMP(a_wr_state, ram_we, state_q == ST_IDLE || state_q == ST_SCAN, "RAM write outside push or remove")
	`BDWS_ASSERT_IMP(a_shift_hazard, ram_we && ram_re, ram_waddr != ram_raddr, "shift write collides with read")
	`BDWS_ASSERT_NXT(a_push_grows, acc && !full && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK), used_q == $past(used_q) + 1'b1, "push did not add an entry")

endmodule
